### design/jtl_pkg.sv
// Shared types, character codes, token kinds and keyword tables of the JSON token lexer.
package jtl_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_LIT
  } mode_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_EMIT_A,
    SEQ_EMIT_B,
    SEQ_RUN_RD,
    SEQ_RUN_OUT
  } seq_t;

  localparam logic [3:0] KIND_OPEN     = 4'd0;
  localparam logic [3:0] KIND_CLOSE    = 4'd1;
  localparam logic [3:0] KIND_COLON    = 4'd2;
  localparam logic [3:0] KIND_COMMA    = 4'd3;
  localparam logic [3:0] KIND_STRING   = 4'd4;
  localparam logic [3:0] KIND_INTEGER  = 4'd5;
  localparam logic [3:0] KIND_TRUE     = 4'd6;
  localparam logic [3:0] KIND_FALSE    = 4'd7;
  localparam logic [3:0] KIND_NULL     = 4'd8;
  localparam logic [3:0] KIND_LINE_END = 4'd9;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [2:0] POS_SAT = 3'd6;

  typedef struct packed {
    logic [3:0]         token_kind;
    logic signed [31:0] int_value;
    logic [7:0]         text_byte;
    logic               text_byte_valid;
    logic               last;
  } result_t;

  typedef struct packed {
    logic       start;
    logic       append;
    logic [7:0] ch;
  } lit_op_t;

  typedef struct packed {
    logic               valid;
    logic [3:0]         kind;
    logic signed [31:0] value;
  } lit_tok_t;

  function automatic logic [7:0] word_true(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h74;
      3'd1: ch = 8'h72;
      3'd2: ch = 8'h75;
      3'd3: ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] word_false(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h66;
      3'd1: ch = 8'h61;
      3'd2: ch = 8'h6C;
      3'd3: ch = 8'h73;
      3'd4: ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] word_null(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h6E;
      3'd1: ch = 8'h75;
      3'd2: ch = 8'h6C;
      3'd3: ch = 8'h6C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

### design/jtl_text_buf.sv
// Text store: synchronous single-write, single-read memory with a registered read port.
module jtl_text_buf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/jtl_lit_acc.sv
// Literal classifier: tracks keyword matches and accumulates the signed decimal value per character.
module jtl_lit_acc (
  input  logic              clk,
  input  logic              rst_n,
  input  jtl_pkg::lit_op_t  op,
  output jtl_pkg::lit_tok_t tok
);
  import jtl_pkg::*;

  logic [2:0]  pos_r, pos_nxt;
  logic        t_r, t_nxt;
  logic        f_r, f_nxt;
  logic        n_r, n_nxt;
  logic        neg_r, neg_nxt;
  logic        ok_r, ok_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] acc10;
  logic [31:0] dig;
  logic        is_digit;

  assign is_digit = (op.ch >= CH_0) && (op.ch <= CH_9);
  assign dig      = {28'd0, op.ch[3:0]};
  assign acc10    = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0};

  always_comb begin
    pos_nxt = pos_r;
    t_nxt   = t_r;
    f_nxt   = f_r;
    n_nxt   = n_r;
    neg_nxt = neg_r;
    ok_nxt  = ok_r;
    acc_nxt = acc_r;
    if (op.start) begin
      pos_nxt = 3'd1;
      t_nxt   = (op.ch == CH_LC_T);
      f_nxt   = (op.ch == CH_LC_F);
      n_nxt   = (op.ch == CH_LC_N);
      neg_nxt = (op.ch == CH_MINUS);
      ok_nxt  = is_digit || (op.ch == CH_MINUS);
      acc_nxt = is_digit ? dig : 32'd0;
    end else if (op.append) begin
      pos_nxt = (pos_r == POS_SAT) ? POS_SAT : pos_r + 3'd1;
      t_nxt   = t_r && (pos_r < 3'd4) && (op.ch == word_true(pos_r));
      f_nxt   = f_r && (pos_r < 3'd5) && (op.ch == word_false(pos_r));
      n_nxt   = n_r && (pos_r < 3'd4) && (op.ch == word_null(pos_r));
      ok_nxt  = ok_r && is_digit;
      if (is_digit) begin
        acc_nxt = neg_r ? acc10 - dig : acc10 + dig;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 3'd0;
      t_r   <= 1'b0;
      f_r   <= 1'b0;
      n_r   <= 1'b0;
      neg_r <= 1'b0;
      ok_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      t_r   <= t_nxt;
      f_r   <= f_nxt;
      n_r   <= n_nxt;
      neg_r <= neg_nxt;
      ok_r  <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_comb begin
    tok.valid = 1'b1;
    tok.value = '0;
    if (t_r && (pos_r == 3'd4)) begin
      tok.kind = KIND_TRUE;
    end else if (f_r && (pos_r == 3'd5)) begin
      tok.kind = KIND_FALSE;
    end else if (n_r && (pos_r == 3'd4)) begin
      tok.kind = KIND_NULL;
    end else begin
      tok.kind  = KIND_INTEGER;
      tok.valid = ok_r;
      tok.value = acc_r;
    end
  end

endmodule

### design/jtl_out_reg.sv
// Output register: holds one result until the receiver takes it.
module jtl_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  jtl_pkg::result_t   data,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_token_kind,
  output logic signed [31:0] out_int_value,
  output logic [7:0]         out_text_byte,
  output logic               out_text_byte_valid,
  output logic               out_last
);
  import jtl_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign can_load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

  assign out_valid           = valid_r;
  assign out_token_kind      = data_r.token_kind;
  assign out_int_value       = data_r.int_value;
  assign out_text_byte       = data_r.text_byte;
  assign out_text_byte_valid = data_r.text_byte_valid;
  assign out_last            = data_r.last;

endmodule

### design/json_token_lexer_top.sv
// Top level of the JSON token lexer: character decode, string readout sequencer and output.
//
// The block takes one received character per input transfer on in_char and
// produces a run of token results on the out_ channel, the final one of each
// run marked by out_last. A character that completes no token produces no
// result at all.
// Each character is decoded in the cycle after its transfer. The first result
// of its run is then loaded into the output register from an emit state,
// waiting there while the output register is still full; a string run reads
// the text memory first. A closing quote reads the string back from the text
// memory one byte per read and output step.
// in_ready is high only while no character is being processed. When the
// receiver stalls, the pending result waits in the output register and the
// sequencer holds until that register frees up.
// Reset returns the lexer to idle with no text collected; the text memory
// needs no clearing, since only entries written for the current string are
// read back.
module json_token_lexer_top #(
  parameter int MAX_TEXT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_token_kind,
  output logic signed [31:0] out_int_value,
  output logic [7:0]         out_text_byte,
  output logic               out_text_byte_valid,
  output logic               out_last
);
  import jtl_pkg::*;

  localparam int AW = $clog2(MAX_TEXT);
  localparam int CW = $clog2(MAX_TEXT + 1);

  seq_t               seq_r, seq_nxt;
  mode_t              mode_r, dec_mode_nxt;
  logic               cr_r;
  logic [CW-1:0]      count_r, dec_cnt_nxt;
  logic [7:0]         c_r;
  logic [3:0]         tok_a_kind_r;
  logic signed [31:0] tok_a_val_r;
  logic               tok_b_v_r;
  logic [3:0]         tok_b_kind_r;
  logic [CW-1:0]      run_len_r;
  logic [AW-1:0]      idx_r;

  logic               exec;
  logic               keep_ok;
  logic               line_end;
  logic               is_digit;
  logic               is_lit_start;
  logic               is_lit_char;
  logic               punct_hit;
  logic [3:0]         punct_kind;
  logic [7:0]         esc_char;
  logic               do_idle;
  logic               dec_wr;
  logic [7:0]         dec_wr_data;
  logic               dec_lit_start;
  logic               dec_lit_append;
  logic               dec_a_v;
  logic               dec_b_v;
  logic [3:0]         dec_b_kind;
  logic               dec_run;
  logic               idx_last;

  lit_op_t            lit_op;
  lit_tok_t           lit_tok;
  logic               mem_wr_en;
  logic               mem_rd_en;
  logic [7:0]         mem_rd_data;
  logic               out_load;
  logic               out_can_load;
  result_t            out_data;

  assign exec     = (seq_r == SEQ_EXEC);
  assign keep_ok  = count_r < CW'(MAX_TEXT);
  assign line_end = (c_r == CH_LF) && cr_r;
  assign is_digit = (c_r >= CH_0) && (c_r <= CH_9);
  assign is_lit_start = is_digit || (c_r inside {CH_MINUS, CH_LC_T, CH_LC_F, CH_LC_N});
  assign is_lit_char  = is_digit || (c_r == CH_MINUS) ||
                        ((c_r >= CH_LC_A) && (c_r <= CH_LC_Z)) ||
                        ((c_r >= CH_UC_A) && (c_r <= CH_UC_Z));
  assign idx_last = (CW'(idx_r) + CW'(1)) == run_len_r;

  always_comb begin
    punct_hit  = 1'b1;
    punct_kind = KIND_OPEN;
    case (c_r)
      CH_LBRACE: punct_kind = KIND_OPEN;
      CH_RBRACE: punct_kind = KIND_CLOSE;
      CH_COLON:  punct_kind = KIND_COLON;
      CH_COMMA:  punct_kind = KIND_COMMA;
      default:   punct_hit  = 1'b0;
    endcase
  end

  always_comb begin
    case (c_r)
      CH_LC_N: esc_char = CH_LF;
      CH_LC_R: esc_char = CH_CR;
      CH_LC_T: esc_char = CH_TAB;
      default: esc_char = c_r;
    endcase
  end

  always_comb begin
    dec_mode_nxt   = mode_r;
    dec_cnt_nxt    = count_r;
    dec_wr         = 1'b0;
    dec_wr_data    = c_r;
    dec_lit_start  = 1'b0;
    dec_lit_append = 1'b0;
    dec_a_v        = 1'b0;
    dec_b_v        = 1'b0;
    dec_b_kind     = KIND_LINE_END;
    dec_run        = 1'b0;
    do_idle        = 1'b0;
    if (line_end) begin
      if (mode_r == MODE_LIT) begin
        dec_a_v      = lit_tok.valid;
        dec_mode_nxt = MODE_IDLE;
        dec_cnt_nxt  = '0;
      end
      dec_b_v = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          do_idle = 1'b1;
        end
        MODE_STR: begin
          if (c_r == CH_BSLASH) begin
            dec_mode_nxt = MODE_ESC;
          end else if (c_r == CH_QUOTE) begin
            dec_mode_nxt = MODE_IDLE;
            dec_cnt_nxt  = '0;
            if (count_r == '0) begin
              dec_b_v    = 1'b1;
              dec_b_kind = KIND_STRING;
            end else begin
              dec_run = 1'b1;
            end
          end else if (keep_ok) begin
            dec_wr      = 1'b1;
            dec_cnt_nxt = count_r + CW'(1);
          end
        end
        MODE_ESC: begin
          dec_mode_nxt = MODE_STR;
          dec_wr_data  = esc_char;
          if (keep_ok) begin
            dec_wr      = 1'b1;
            dec_cnt_nxt = count_r + CW'(1);
          end
        end
        MODE_LIT: begin
          if (is_lit_char) begin
            if (keep_ok) begin
              dec_lit_append = 1'b1;
              dec_cnt_nxt    = count_r + CW'(1);
            end
          end else begin
            dec_mode_nxt = MODE_IDLE;
            dec_a_v      = lit_tok.valid && (count_r != '0);
            dec_cnt_nxt  = '0;
            do_idle      = 1'b1;
          end
        end
      endcase
    end
    if (do_idle) begin
      if (c_r == CH_QUOTE) begin
        dec_mode_nxt = MODE_STR;
        dec_cnt_nxt  = '0;
      end else if (punct_hit) begin
        dec_b_v    = 1'b1;
        dec_b_kind = punct_kind;
      end else if (is_lit_start) begin
        dec_mode_nxt  = MODE_LIT;
        dec_cnt_nxt   = CW'(1);
        dec_lit_start = 1'b1;
      end
    end
  end

  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          seq_nxt = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        if (dec_a_v) begin
          seq_nxt = SEQ_EMIT_A;
        end else if (dec_b_v) begin
          seq_nxt = SEQ_EMIT_B;
        end else if (dec_run) begin
          seq_nxt = SEQ_RUN_RD;
        end else begin
          seq_nxt = SEQ_IDLE;
        end
      end
      SEQ_EMIT_A: begin
        if (out_can_load) begin
          seq_nxt = tok_b_v_r ? SEQ_EMIT_B : SEQ_IDLE;
        end
      end
      SEQ_EMIT_B: begin
        if (out_can_load) begin
          seq_nxt = SEQ_IDLE;
        end
      end
      SEQ_RUN_RD: begin
        seq_nxt = SEQ_RUN_OUT;
      end
      SEQ_RUN_OUT: begin
        if (out_can_load) begin
          seq_nxt = idx_last ? SEQ_IDLE : SEQ_RUN_RD;
        end
      end
      default: seq_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mem_rd_en = 1'b0;
    out_data  = '0;
    unique case (seq_r)
      SEQ_IDLE: begin
        in_ready = 1'b1;
      end
      SEQ_EXEC: begin
        in_ready = 1'b0;
      end
      SEQ_EMIT_A: begin
        out_load            = out_can_load;
        out_data.token_kind = tok_a_kind_r;
        out_data.int_value  = tok_a_val_r;
        out_data.last       = !tok_b_v_r;
      end
      SEQ_EMIT_B: begin
        out_load            = out_can_load;
        out_data.token_kind = tok_b_kind_r;
        out_data.last       = 1'b1;
      end
      SEQ_RUN_RD: begin
        mem_rd_en = 1'b1;
      end
      SEQ_RUN_OUT: begin
        out_load                 = out_can_load;
        out_data.token_kind      = KIND_STRING;
        out_data.text_byte       = mem_rd_data;
        out_data.text_byte_valid = 1'b1;
        out_data.last            = idx_last;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r     <= SEQ_IDLE;
      mode_r    <= MODE_IDLE;
      cr_r      <= 1'b0;
      count_r   <= '0;
      tok_b_v_r <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      if (exec) begin
        mode_r    <= dec_mode_nxt;
        cr_r      <= (c_r == CH_CR);
        count_r   <= dec_cnt_nxt;
        tok_b_v_r <= dec_b_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      c_r <= in_char;
    end
    if (exec) begin
      tok_a_kind_r <= lit_tok.kind;
      tok_a_val_r  <= lit_tok.value;
      tok_b_kind_r <= dec_b_kind;
      run_len_r    <= count_r;
      idx_r        <= '0;
    end else if ((seq_r == SEQ_RUN_OUT) && out_can_load && !idx_last) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  assign mem_wr_en     = exec && dec_wr;
  assign lit_op.start  = exec && dec_lit_start;
  assign lit_op.append = exec && dec_lit_append;
  assign lit_op.ch     = c_r;

  jtl_lit_acc u_lit (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (lit_op),
    .tok   (lit_tok)
  );

  jtl_text_buf #(
    .DEPTH (MAX_TEXT),
    .AW    (AW)
  ) u_text (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (dec_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (idx_r),
    .rd_data (mem_rd_data)
  );

  jtl_out_reg u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (out_load),
    .data                (out_data),
    .can_load            (out_can_load),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_token_kind      (out_token_kind),
    .out_int_value       (out_int_value),
    .out_text_byte       (out_text_byte),
    .out_text_byte_valid (out_text_byte_valid),
    .out_last            (out_last)
  );

  a_no_write_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SEQ_RUN_RD || seq_r == SEQ_RUN_OUT) |-> !mem_wr_en)
    else $error("text memory written while a string is being read back");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TEXT))
    else $error("text count exceeds the store depth");

  a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SEQ_RUN_RD) |-> (run_len_r != '0) && (CW'(idx_r) < run_len_r))
    else $error("string readout index outside the collected text");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (seq_r == SEQ_EXEC))
    else $error("accepted character not decoded in the next cycle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_can_load)
    else $error("result loaded over an untaken result");

endmodule
